/* hw/rtl/cc20_pkg.sv */
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and helpers for the four-block chacha20 keystream
// generator.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam int BLOCKS_PER_ITEM = 4;
  localparam int DOUBLE_ROUNDS   = 10;
  localparam int ROUNDS          = 2 * DOUBLE_ROUNDS;
  localparam int ROUND_W         = $clog2(ROUNDS);
  localparam int WORDS           = 16;
  localparam int WORD_W          = 4;
  localparam int BLK_W           = 2;
  localparam int LANES           = 4;
  localparam int STEPS           = 4;
  localparam int STEP_W          = 2;

  localparam int REG_W = 64;
  localparam int IDX_W = 4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SIGMA_LO = 4'd0;
  localparam logic [IDX_W-1:0] REG_SIGMA_HI = 4'd1;
  localparam logic [IDX_W-1:0] REG_KEY_A    = 4'd2;
  localparam logic [IDX_W-1:0] REG_KEY_B    = 4'd3;
  localparam logic [IDX_W-1:0] REG_KEY_C    = 4'd4;
  localparam logic [IDX_W-1:0] REG_KEY_D    = 4'd5;
  localparam logic [IDX_W-1:0] REG_NONCE_LO = 4'd6;
  localparam logic [IDX_W-1:0] REG_NONCE_HI = 4'd7;

  // quarter-round step codes and their rotations
  localparam logic [STEP_W-1:0] STEP_AD16 = 2'd0;
  localparam logic [STEP_W-1:0] STEP_CB12 = 2'd1;
  localparam logic [STEP_W-1:0] STEP_AD8  = 2'd2;
  localparam logic [STEP_W-1:0] STEP_CB7  = 2'd3;

  typedef logic [31:0] word_t;
  typedef word_t [WORDS-1:0] state_t;

  typedef struct packed {
    logic [63:0] sigma_lo;
    logic [63:0] sigma_hi;
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] key_d;
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
  } cfg_t;

  function automatic state_t init_state(input cfg_t c, input word_t ctr);
    state_t s;
    s[0]  = c.sigma_lo[31:0];
    s[1]  = c.sigma_lo[63:32];
    s[2]  = c.sigma_hi[31:0];
    s[3]  = c.sigma_hi[63:32];
    s[4]  = c.key_a[31:0];
    s[5]  = c.key_a[63:32];
    s[6]  = c.key_b[31:0];
    s[7]  = c.key_b[63:32];
    s[8]  = c.key_c[31:0];
    s[9]  = c.key_c[63:32];
    s[10] = c.key_d[31:0];
    s[11] = c.key_d[63:32];
    s[12] = ctr;
    s[13] = c.nonce_lo[31:0];
    s[14] = c.nonce_lo[63:32];
    s[15] = c.nonce_hi;
    return s;
  endfunction

endpackage

/* hw/rtl/cc20_if.sv */
// ----------------------------------------------------------------------------
// cc20 channel interfaces
// Valid/ready channels for counter items in and keystream items out.
// ----------------------------------------------------------------------------
interface cc20_ctr_if;
  logic        valid;
  logic        ready;
  logic [31:0] counter;

  modport source (output valid, output counter, input ready);
  modport sink   (input valid, input counter, output ready);
endinterface

interface cc20_ks_if;
  logic        valid;
  logic        ready;
  logic [1:0]  block_index;
  logic [3:0]  word_index;
  logic [31:0] keystream_word;
  logic        last;

  modport source (output valid, output block_index, output word_index,
                  output keystream_word, output last, input ready);
  modport sink   (input valid, input block_index, input word_index,
                  input keystream_word, input last, output ready);
endinterface

/* hw/rtl/cc20_arx.sv */
// ----------------------------------------------------------------------------
// cc20_arx
// One add-xor-rotate step of a quarter round, shared over all four steps.
// ----------------------------------------------------------------------------
module cc20_arx (
  input  logic [cc20_pkg::STEP_W-1:0] step,
  input  cc20_pkg::word_t             x,
  input  cc20_pkg::word_t             y,
  input  cc20_pkg::word_t             z,
  output cc20_pkg::word_t             x_new,
  output cc20_pkg::word_t             z_new
);

  cc20_pkg::word_t sum;
  cc20_pkg::word_t mix;

  assign sum   = x + y;
  assign mix   = z ^ sum;
  assign x_new = sum;

  always_comb begin
    unique case (step)
      cc20_pkg::STEP_AD16: z_new = {mix[15:0], mix[31:16]};
      cc20_pkg::STEP_CB12: z_new = {mix[19:0], mix[31:20]};
      cc20_pkg::STEP_AD8:  z_new = {mix[23:0], mix[31:24]};
      cc20_pkg::STEP_CB7:  z_new = {mix[24:0], mix[31:25]};
      default:             z_new = mix;
    endcase
  end

endmodule

/* hw/rtl/chacha20_block4_keystream_top.sv */
// ----------------------------------------------------------------------------
// chacha20_block4_keystream_top
// Four consecutive chacha20 keystream blocks per counter item.
// ----------------------------------------------------------------------------
// One counter item yields 64 keystream words: blocks counter+0..counter+3
// (each wrapping mod 2^32), 16 words each, in order, last set on the final
// word. Each block first runs 20 rounds on four parallel add-xor-rotate lanes,
// four steps per round, and then emits its 16 words one per cycle while the
// sink does not stall, through an output register, adding the initial state
// back in. The input is ready only between items. Configuration must be
// written through cfg_we/cfg_index/cfg_data only while the block is idle;
// the block itself does not enforce this. Indexes above 7 are ignored.
module chacha20_block4_keystream_top (
  input  logic                           clk,
  input  logic                           rst,
  cc20_ctr_if.sink                       req,
  cc20_ks_if.source                      ks,
  input  logic                           cfg_we,
  input  logic [cc20_pkg::IDX_W-1:0]     cfg_index,
  input  logic [cc20_pkg::REG_W-1:0]     cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]                     state;
  cc20_pkg::cfg_t                 cfg;
  cc20_pkg::state_t               w;
  cc20_pkg::state_t               w_next;
  cc20_pkg::word_t                blk_ctr;
  logic [cc20_pkg::BLK_W-1:0]     blk;
  logic [cc20_pkg::WORD_W-1:0]    word;
  logic [cc20_pkg::ROUND_W-1:0]   rnd;
  logic [cc20_pkg::STEP_W-1:0]    step;

  logic                           ovalid;
  logic [cc20_pkg::BLK_W-1:0]     oblk;
  logic [cc20_pkg::WORD_W-1:0]    oword;
  cc20_pkg::word_t                okey;
  logic                           olast;

  cc20_pkg::state_t               init_start;
  cc20_pkg::state_t               init_cur;
  cc20_pkg::state_t               init_nxt;

  logic [cc20_pkg::WORD_W-1:0]    x_idx [cc20_pkg::LANES];
  logic [cc20_pkg::WORD_W-1:0]    y_idx [cc20_pkg::LANES];
  logic [cc20_pkg::WORD_W-1:0]    z_idx [cc20_pkg::LANES];
  cc20_pkg::word_t                lane_xn [cc20_pkg::LANES];
  cc20_pkg::word_t                lane_zn [cc20_pkg::LANES];

  logic                           emit_load;
  logic                           blk_done;
  logic                           item_done;

  assign init_start = cc20_pkg::init_state(cfg, req.counter);
  assign init_cur   = cc20_pkg::init_state(cfg, blk_ctr);
  assign init_nxt   = cc20_pkg::init_state(cfg, blk_ctr + 32'd1);

  assign req.ready  = (state == ST_IDLE);

  assign emit_load  = (state == ST_EMIT) && (!ovalid || ks.ready);
  assign blk_done   = (word == cc20_pkg::WORD_W'(cc20_pkg::WORDS - 1));
  assign item_done  = blk_done && (blk == cc20_pkg::BLK_W'(cc20_pkg::BLOCKS_PER_ITEM - 1));

  // word positions each lane works on: columns on even rounds, diagonals on odd
  always_comb begin
    int dg;
    int ai;
    int bi;
    int ci;
    int di;
    dg = rnd[0] ? 1 : 0;
    for (int q = 0; q < cc20_pkg::LANES; q++) begin
      ai = q;
      bi = 4 + ((q + dg) % 4);
      ci = 8 + ((q + 2 * dg) % 4);
      di = 12 + ((q + 3 * dg) % 4);
      // odd steps update c from d and rotate b
      x_idx[q] = step[0] ? cc20_pkg::WORD_W'(ci) : cc20_pkg::WORD_W'(ai);
      y_idx[q] = step[0] ? cc20_pkg::WORD_W'(di) : cc20_pkg::WORD_W'(bi);
      z_idx[q] = step[0] ? cc20_pkg::WORD_W'(bi) : cc20_pkg::WORD_W'(di);
    end
  end

  for (genvar g = 0; g < cc20_pkg::LANES; g++) begin : g_lane
    cc20_arx u_arx (
      .step  (step),
      .x     (w[x_idx[g]]),
      .y     (w[y_idx[g]]),
      .z     (w[z_idx[g]]),
      .x_new (lane_xn[g]),
      .z_new (lane_zn[g])
    );
  end

  always_comb begin
    w_next = w;
    for (int q = 0; q < cc20_pkg::LANES; q++) begin
      w_next[x_idx[q]] = lane_xn[q];
      w_next[z_idx[q]] = lane_zn[q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ovalid <= 1'b0;
      cfg    <= '0;
      blk    <= '0;
      word   <= '0;
      rnd    <= '0;
      step   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cc20_pkg::REG_SIGMA_LO: cfg.sigma_lo <= cfg_data;
          cc20_pkg::REG_SIGMA_HI: cfg.sigma_hi <= cfg_data;
          cc20_pkg::REG_KEY_A:    cfg.key_a    <= cfg_data;
          cc20_pkg::REG_KEY_B:    cfg.key_b    <= cfg_data;
          cc20_pkg::REG_KEY_C:    cfg.key_c    <= cfg_data;
          cc20_pkg::REG_KEY_D:    cfg.key_d    <= cfg_data;
          cc20_pkg::REG_NONCE_LO: cfg.nonce_lo <= cfg_data;
          cc20_pkg::REG_NONCE_HI: cfg.nonce_hi <= cfg_data[31:0];
          default: ;
        endcase
      end

      // a fresh load below takes over the output register
      if (ovalid && ks.ready && !emit_load) begin
        ovalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            blk_ctr <= req.counter;
            w       <= init_start;
            blk     <= '0;
            rnd     <= '0;
            step    <= '0;
            state   <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          w    <= w_next;
          step <= step + 1'b1;
          if (step == cc20_pkg::STEP_CB7) begin
            if (rnd == cc20_pkg::ROUND_W'(cc20_pkg::ROUNDS - 1)) begin
              word  <= '0;
              state <= ST_EMIT;
            end else begin
              rnd <= rnd + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            ovalid <= 1'b1;
            oblk   <= blk;
            oword  <= word;
            okey   <= w[word] + init_cur[word];
            olast  <= item_done;
            word   <= word + 1'b1;
            if (item_done) begin
              state <= ST_IDLE;
            end else if (blk_done) begin
              // next block starts from a fresh initial state
              blk     <= blk + 1'b1;
              blk_ctr <= blk_ctr + 32'd1;
              w       <= init_nxt;
              rnd     <= '0;
              step    <= '0;
              state   <= ST_ROUND;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign ks.valid          = ovalid;
  assign ks.block_index    = oblk;
  assign ks.word_index     = oword;
  assign ks.keystream_word = okey;
  assign ks.last           = olast;

endmodule

/* hw/rtl/cc20_chk.sv */
// ----------------------------------------------------------------------------
// cc20_chk
// Port-level checks for the keystream generator, bound to the top level.
// ----------------------------------------------------------------------------
module cc20_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_block_index,
  input logic [3:0]  out_word_index,
  input logic [31:0] out_keystream_word,
  input logic        out_last
);

  // nothing pending straight out of reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // an accepted counter keeps the input closed while its blocks are worked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted item");

  // no new counter while a word short of the item's final one is waiting
  a_busy_mid_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input ready before the item's final word");

  // the final word always sits at the last position of a block
  a_last_position: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_word_index == 4'd15))
    else $error("last flag on a word that ends no block");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_keystream_word) && $stable(out_block_index)
       && $stable(out_word_index) && $stable(out_last)))
    else $error("stalled output item changed");

endmodule

bind chacha20_block4_keystream_top cc20_chk u_cc20_chk (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (req.valid),
  .in_ready           (req.ready),
  .out_valid          (ks.valid),
  .out_ready          (ks.ready),
  .out_block_index    (ks.block_index),
  .out_word_index     (ks.word_index),
  .out_keystream_word (ks.keystream_word),
  .out_last           (ks.last)
);
